// File: rtl/assert_macros.svh
// Assertion macros shared by the vector grid sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define VGS_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("vgs same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define VGS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("vgs next-cycle check failed");

`else

`define VGS_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define VGS_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: rtl/vgs_pkg.sv
// Shared constants, codes and types of the vector grid sampler.
`timescale 1ns / 1ps

package vgs_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int DEPTH      = MAX_COLS * MAX_ROWS;
   localparam int VALUE_BITS = 16;
   localparam int CELL_BITS  = 2 * VALUE_BITS;
   // positions and the Q8.8 reciprocals share the same fraction width
   localparam int FRAC_BITS  = 8;
   localparam int POS_BITS   = 15;
   localparam int SIZE_BITS  = 7;
   localparam int RECIP_BITS = 16;

   // neighborhood and arithmetic widths
   localparam int NBR_COUNT  = 5;
   localparam int NBR_BITS   = $clog2(NBR_COUNT);
   localparam int STEP_BITS  = 3;
   localparam int SUM_BITS   = VALUE_BITS + 3;
   localparam int COEF_BITS  = RECIP_BITS + 1;
   localparam int BASE_BITS  = VALUE_BITS + 2;
   localparam int PROD_BITS  = SUM_BITS + COEF_BITS;
   localparam int RES_BITS   = PROD_BITS - FRAC_BITS + 1;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_DIV    = 2'd2,
      CMD_LAP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_INV_TWO_CW  = 2'd2,
      REG_INV_CW_SQ   = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  eff_width;
      logic [SIZE_BITS-1:0]  eff_height;
      logic [RECIP_BITS-1:0] inv_two_cell_width;
      logic [RECIP_BITS-1:0] inv_cell_width_sq;
   } cfg_type;

   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [ADDR_BITS-1:0] addr;
      logic [CELL_BITS-1:0] wdata;
   } mem_cmd_type;

endpackage

// File: rtl/vgs_if.sv
// Request and response channel interfaces of the vector grid sampler.
`timescale 1ns / 1ps

interface vgs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           command;
   logic [vgs_pkg::COL_BITS-1:0]         cell_col;
   logic [vgs_pkg::ROW_BITS-1:0]         cell_row;
   logic signed [vgs_pkg::VALUE_BITS-1:0] write_vx;
   logic signed [vgs_pkg::VALUE_BITS-1:0] write_vy;
   logic signed [vgs_pkg::POS_BITS-1:0]   pos_x;
   logic signed [vgs_pkg::POS_BITS-1:0]   pos_y;

   modport source (output valid, command, cell_col, cell_row, write_vx, write_vy,
                   pos_x, pos_y, input ready);
   modport sink   (input valid, command, cell_col, cell_row, write_vx, write_vy,
                   pos_x, pos_y, output ready);
endinterface

interface vgs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vgs_pkg::VALUE_BITS-1:0] result_x;
   logic signed [vgs_pkg::VALUE_BITS-1:0] result_y;
   logic                                 border_flag;
   logic                                 saturated;

   modport source (output valid, result_x, result_y, border_flag, saturated,
                   input ready);
   modport sink   (input valid, result_x, result_y, border_flag, saturated,
                   output ready);
endinterface

// File: rtl/vgs_csr.sv
// Configuration registers with an APB-style write and read port.
`timescale 1ns / 1ps

module vgs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [vgs_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [vgs_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [vgs_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready,
   output vgs_pkg::cfg_type                   cfg
);

   localparam int SB = vgs_pkg::SIZE_BITS;
   localparam int RB = vgs_pkg::RECIP_BITS;

   logic [SB-1:0]         grid_width_ff;
   logic [SB-1:0]         grid_height_ff;
   logic [RB-1:0]         inv_two_ff;
   logic [RB-1:0]         inv_sq_ff;
   logic                  wr_en;
   vgs_pkg::reg_idx_type  idx;

   function automatic logic [SB-1:0] eff_size(input logic [SB-1:0] v,
                                               input logic [SB-1:0] maxv);
      logic [SB-1:0] r;
      if (v < SB'(2)) begin
         r = SB'(2);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = vgs_pkg::reg_idx_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SB'(64);
         grid_height_ff <= SB'(64);
         inv_two_ff     <= RB'(128);
         inv_sq_ff      <= RB'(256);
      end else if (wr_en) begin
         unique case (idx)
            vgs_pkg::REG_GRID_WIDTH:  grid_width_ff  <= pwdata[SB-1:0];
            vgs_pkg::REG_GRID_HEIGHT: grid_height_ff <= pwdata[SB-1:0];
            vgs_pkg::REG_INV_TWO_CW:  inv_two_ff     <= pwdata[RB-1:0];
            vgs_pkg::REG_INV_CW_SQ:   inv_sq_ff      <= pwdata[RB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         vgs_pkg::REG_GRID_WIDTH:  prdata = vgs_pkg::CSR_DATA_BITS'(grid_width_ff);
         vgs_pkg::REG_GRID_HEIGHT: prdata = vgs_pkg::CSR_DATA_BITS'(grid_height_ff);
         vgs_pkg::REG_INV_TWO_CW:  prdata = vgs_pkg::CSR_DATA_BITS'(inv_two_ff);
         vgs_pkg::REG_INV_CW_SQ:   prdata = vgs_pkg::CSR_DATA_BITS'(inv_sq_ff);
         default:                  prdata = '0;
      endcase
   end

   assign cfg.eff_width          = eff_size(grid_width_ff, SB'(vgs_pkg::MAX_COLS));
   assign cfg.eff_height         = eff_size(grid_height_ff, SB'(vgs_pkg::MAX_ROWS));
   assign cfg.inv_two_cell_width = inv_two_ff;
   assign cfg.inv_cell_width_sq  = inv_sq_ff;

endmodule

// File: rtl/vgs_store.sv
// Single-port vector store with registered read data.
`timescale 1ns / 1ps

module vgs_store (
   input  logic                              clock,
   input  vgs_pkg::mem_cmd_type              cmd,
   output logic [vgs_pkg::CELL_BITS-1:0]     rd_data
);

   logic [vgs_pkg::CELL_BITS-1:0] mem [vgs_pkg::DEPTH];
   logic [vgs_pkg::CELL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.re) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vgs_mac.sv
// Multiply, round half up by the fraction width, and add a base value.
`timescale 1ns / 1ps

module vgs_mac (
   input  logic                                 clock,
   input  logic signed [vgs_pkg::SUM_BITS-1:0]  diff,
   input  logic signed [vgs_pkg::COEF_BITS-1:0] coef,
   input  logic signed [vgs_pkg::BASE_BITS-1:0] base,
   output logic signed [vgs_pkg::RES_BITS-1:0]  result
);

   localparam int PB = vgs_pkg::PROD_BITS;
   localparam int FB = vgs_pkg::FRAC_BITS;

   logic signed [PB-1:0]                  prod_ff;
   logic signed [vgs_pkg::BASE_BITS-1:0]  base_ff;
   logic signed [PB-1:0]                  rnd_full;
   logic signed [PB-FB-1:0]               shifted;

   always_ff @(posedge clock) begin
      prod_ff <= PB'(diff) * PB'(coef);
      base_ff <= base;
   end

   // floor of (prod + half) / 2^FB
   assign rnd_full = prod_ff + PB'(1 << (FB - 1));
   assign shifted  = rnd_full[PB-1:FB];
   assign result   = vgs_pkg::RES_BITS'(shifted) + vgs_pkg::RES_BITS'(base_ff);

endmodule

// File: rtl/vgs_core.sv
// Command sequencer: store access, neighbor gather, interpolation and stencils.
`timescale 1ns / 1ps

module vgs_core (
   input  logic                           clock,
   input  logic                           reset,
   input  vgs_pkg::cfg_type               cfg,
   vgs_req_if.sink                        req,
   vgs_rsp_if.source                      rsp,
   output vgs_pkg::mem_cmd_type           mem_cmd,
   input  logic [vgs_pkg::CELL_BITS-1:0]  mem_rdata
);

   localparam int VB = vgs_pkg::VALUE_BITS;
   localparam int FB = vgs_pkg::FRAC_BITS;
   localparam int CB = vgs_pkg::COL_BITS;
   localparam int RWB = vgs_pkg::ROW_BITS;
   localparam int SB = vgs_pkg::SIZE_BITS;
   localparam int PSB = vgs_pkg::POS_BITS;
   localparam int NB = vgs_pkg::NBR_BITS;
   localparam int TB = vgs_pkg::STEP_BITS;
   localparam int SUMB = vgs_pkg::SUM_BITS;
   localparam int COB = vgs_pkg::COEF_BITS;
   localparam int BSB = vgs_pkg::BASE_BITS;
   localparam int RSB = vgs_pkg::RES_BITS;
   localparam int NC = vgs_pkg::NBR_COUNT;

   localparam logic [NB-1:0] READS_FOUR = NB'(NC - 1);
   localparam logic [NB-1:0] READS_FIVE = NB'(NC);
   localparam logic [TB-1:0] LAST_SAMPLE_STEP  = TB'(4);
   localparam logic [TB-1:0] LAST_STENCIL_STEP = TB'(1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CALC = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   vgs_pkg::cmd_type       cmd_ff;
   vgs_pkg::cmd_type       req_cmd;
   logic [CB-1:0]          col_ff;
   logic [RWB-1:0]         row_ff;
   logic [FB-1:0]          tx_ff, ty_ff;
   logic [NB-1:0]          cnt_ff;
   logic [TB-1:0]          step_ff;
   logic                   rd_vld_ff;
   logic [NB-1:0]          rd_idx_ff;
   logic [vgs_pkg::CELL_BITS-1:0] nbr_ff [NC];
   logic signed [VB-1:0]   lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic signed [VB-1:0]   pend_x_ff, pend_y_ff;
   logic                   pend_border_ff, pend_sat_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [VB-1:0]   rsp_x_ff, rsp_y_ff;
   logic                   rsp_border_ff, rsp_sat_ff;

   logic                   accept;
   logic                   border;
   logic [SB-1:0]          w_m2, h_m2;
   logic signed [PSB-1:0]  lim_x, lim_y, px, py;
   logic [NB-1:0]          n_reads;
   logic [TB-1:0]          last_step;
   logic                   col_inc, col_dec, row_inc, row_dec;
   logic [CB-1:0]          rd_col;
   logic [RWB-1:0]         rd_row;
   logic                   out_free;
   logic                   load_out;

   logic signed [VB-1:0]   nx [NC];
   logic signed [VB-1:0]   ny [NC];
   logic signed [SUMB-1:0] div_sum, lap_x, lap_y, cen4_x, cen4_y;
   logic signed [SUMB-1:0] diff_x, diff_y;
   logic signed [COB-1:0]  coef;
   logic signed [BSB-1:0]  base_x, base_y;
   logic signed [RSB-1:0]  res_x, res_y;
   logic [VB:0]            sat_x, sat_y;

   function automatic logic [VB:0] sat_value(input logic signed [RSB-1:0] v);
      logic signed [RSB-1:0] hi_lim;
      logic signed [RSB-1:0] lo_lim;
      logic [VB:0]           r;
      hi_lim = RSB'((1 << (VB - 1)) - 1);
      lo_lim = ~hi_lim;
      if (v > hi_lim) begin
         r = {1'b1, hi_lim[VB-1:0]};
      end else if (v < lo_lim) begin
         r = {1'b1, lo_lim[VB-1:0]};
      end else begin
         r = {1'b0, v[VB-1:0]};
      end
      return r;
   endfunction

   assign req_cmd   = vgs_pkg::cmd_type'(req.command);
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   // clamp the sample position to [0, size-2] cells
   assign w_m2  = cfg.eff_width - SB'(2);
   assign h_m2  = cfg.eff_height - SB'(2);
   assign lim_x = {1'b0, w_m2[CB-1:0], {FB{1'b0}}};
   assign lim_y = {1'b0, h_m2[RWB-1:0], {FB{1'b0}}};

   always_comb begin
      if (req.pos_x < 0) begin
         px = '0;
      end else if (req.pos_x > lim_x) begin
         px = lim_x;
      end else begin
         px = req.pos_x;
      end
      if (req.pos_y < 0) begin
         py = '0;
      end else if (req.pos_y > lim_y) begin
         py = lim_y;
      end else begin
         py = req.pos_y;
      end
   end

   assign border = (req.cell_col == '0) ||
                   ((SB'(req.cell_col) + SB'(1)) >= cfg.eff_width) ||
                   (req.cell_row == '0) ||
                   ((SB'(req.cell_row) + SB'(1)) >= cfg.eff_height);

   assign n_reads   = (cmd_ff == vgs_pkg::CMD_LAP) ? READS_FIVE : READS_FOUR;
   assign last_step = (cmd_ff == vgs_pkg::CMD_SAMPLE) ? LAST_SAMPLE_STEP
                                                       : LAST_STENCIL_STEP;

   // neighbor order: sample reads the 2x2 block row by row; stencils read
   // right, left, top, bottom, then centre
   always_comb begin
      col_inc = 1'b0;
      col_dec = 1'b0;
      row_inc = 1'b0;
      row_dec = 1'b0;
      if (cmd_ff == vgs_pkg::CMD_SAMPLE) begin
         col_inc = cnt_ff[0];
         row_inc = cnt_ff[1];
      end else begin
         case (cnt_ff)
            NB'(0):  col_inc = 1'b1;
            NB'(1):  col_dec = 1'b1;
            NB'(2):  row_inc = 1'b1;
            NB'(3):  row_dec = 1'b1;
            default: ;
         endcase
      end
   end

   assign rd_col = col_inc ? col_ff + CB'(1) : (col_dec ? col_ff - CB'(1) : col_ff);
   assign rd_row = row_inc ? row_ff + RWB'(1) : (row_dec ? row_ff - RWB'(1) : row_ff);

   always_comb begin
      mem_cmd.we    = accept && (req_cmd == vgs_pkg::CMD_WRITE);
      mem_cmd.re    = (state_ff == ST_READ) && (cnt_ff < n_reads);
      mem_cmd.addr  = mem_cmd.we ? {req.cell_row, req.cell_col} : {rd_row, rd_col};
      mem_cmd.wdata = {req.write_vy, req.write_vx};
   end

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         nx[i] = nbr_ff[i][VB-1:0];
         ny[i] = nbr_ff[i][2*VB-1:VB];
      end
   end

   assign cen4_x  = SUMB'(nx[4]) <<< 2;
   assign cen4_y  = SUMB'(ny[4]) <<< 2;
   assign div_sum = SUMB'(nx[0]) - SUMB'(nx[1]) + SUMB'(ny[2]) - SUMB'(ny[3]);
   assign lap_x   = SUMB'(nx[0]) + SUMB'(nx[1]) + SUMB'(nx[2]) + SUMB'(nx[3]) - cen4_x;
   assign lap_y   = SUMB'(ny[0]) + SUMB'(ny[1]) + SUMB'(ny[2]) + SUMB'(ny[3]) - cen4_y;

   always_comb begin
      diff_x = '0;
      diff_y = '0;
      coef   = '0;
      base_x = '0;
      base_y = '0;
      case (cmd_ff)
         vgs_pkg::CMD_SAMPLE: begin
            case (step_ff)
               TB'(0): begin
                  diff_x = SUMB'(nx[1]) - SUMB'(nx[0]);
                  diff_y = SUMB'(ny[1]) - SUMB'(ny[0]);
                  coef   = COB'(tx_ff);
                  base_x = BSB'(nx[0]);
                  base_y = BSB'(ny[0]);
               end
               TB'(1): begin
                  diff_x = SUMB'(nx[3]) - SUMB'(nx[2]);
                  diff_y = SUMB'(ny[3]) - SUMB'(ny[2]);
                  coef   = COB'(tx_ff);
                  base_x = BSB'(nx[2]);
                  base_y = BSB'(ny[2]);
               end
               TB'(3): begin
                  diff_x = SUMB'(hi_x_ff) - SUMB'(lo_x_ff);
                  diff_y = SUMB'(hi_y_ff) - SUMB'(lo_y_ff);
                  coef   = COB'(ty_ff);
                  base_x = BSB'(lo_x_ff);
                  base_y = BSB'(lo_y_ff);
               end
               default: ;
            endcase
         end
         vgs_pkg::CMD_DIV: begin
            diff_x = div_sum;
            coef   = COB'(cfg.inv_two_cell_width);
         end
         vgs_pkg::CMD_LAP: begin
            diff_x = lap_x;
            diff_y = lap_y;
            coef   = COB'(cfg.inv_cell_width_sq);
         end
         default: ;
      endcase
   end

   vgs_mac u_mac_x (
      .clock  (clock),
      .diff   (diff_x),
      .coef   (coef),
      .base   (base_x),
      .result (res_x)
   );

   vgs_mac u_mac_y (
      .clock  (clock),
      .diff   (diff_y),
      .coef   (coef),
      .base   (base_y),
      .result (res_y)
   );

   assign sat_x = sat_value(res_x);
   assign sat_y = sat_value(res_y);

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign load_out = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd != vgs_pkg::CMD_WRITE)) begin
               if ((req_cmd != vgs_pkg::CMD_SAMPLE) && border) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (cnt_ff == n_reads) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (step_ff == last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= mem_cmd.re;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= (state_ff == ST_READ) ? cnt_ff + NB'(1) : '0;
         step_ff      <= (state_ff == ST_CALC) ? step_ff + TB'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         if (req_cmd == vgs_pkg::CMD_SAMPLE) begin
            col_ff <= px[FB +: CB];
            row_ff <= py[FB +: RWB];
         end else begin
            col_ff <= req.cell_col;
            row_ff <= req.cell_row;
         end
         tx_ff          <= px[FB-1:0];
         ty_ff          <= py[FB-1:0];
         // border-cell stencils skip the store entirely
         pend_x_ff      <= '0;
         pend_y_ff      <= '0;
         pend_border_ff <= (req_cmd != vgs_pkg::CMD_SAMPLE) && border;
         pend_sat_ff    <= 1'b0;
      end
      rd_idx_ff <= cnt_ff;
      if (rd_vld_ff) begin
         nbr_ff[rd_idx_ff] <= mem_rdata;
      end
      if ((state_ff == ST_CALC) && (cmd_ff == vgs_pkg::CMD_SAMPLE)) begin
         // a lerp stays between its two end values, so no clipping here
         if (step_ff == TB'(1)) begin
            lo_x_ff <= res_x[VB-1:0];
            lo_y_ff <= res_y[VB-1:0];
         end
         if (step_ff == TB'(2)) begin
            hi_x_ff <= res_x[VB-1:0];
            hi_y_ff <= res_y[VB-1:0];
         end
      end
      if ((state_ff == ST_CALC) && (step_ff == last_step)) begin
         pend_x_ff   <= sat_x[VB-1:0];
         pend_y_ff   <= sat_y[VB-1:0];
         pend_sat_ff <= sat_x[VB] || sat_y[VB];
      end
      if (load_out) begin
         rsp_x_ff      <= pend_x_ff;
         rsp_y_ff      <= pend_y_ff;
         rsp_border_ff <= pend_border_ff;
         rsp_sat_ff    <= pend_sat_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_x    = rsp_x_ff;
   assign rsp.result_y    = rsp_y_ff;
   assign rsp.border_flag = rsp_border_ff;
   assign rsp.saturated   = rsp_sat_ff;

endmodule

// File: rtl/vector_grid_sample_and_stencil.sv
// Top level of the vector grid sampler and stencil unit.
//
// Holds a 64 x 64 grid of Q7.8 velocity vectors in one single-port store
// with registered read data and serves one request at a time. A write
// produces no response. A sample or an inner-cell stencil runs a neighbor
// gather (one store read per cycle, four or five reads) followed by the
// shared multiply-and-round units, three passes for a sample and one for a
// stencil; a stencil on a border cell skips both. The response sits in an
// output register; a request whose result finds that register still full
// waits until it is taken. The store has no reset: reading a cell that was
// never written gives an undefined vector.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_grid_sample_and_stencil (
   input  logic                               clock,
   input  logic                               reset,
   vgs_req_if.sink                            req_ch,
   vgs_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vgs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [vgs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [vgs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   vgs_pkg::cfg_type              cfg;
   vgs_pkg::mem_cmd_type          mem_cmd;
   logic [vgs_pkg::CELL_BITS-1:0] mem_rdata;

   vgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   vgs_store u_store (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (mem_rdata)
   );

   vgs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .mem_cmd   (mem_cmd),
      .mem_rdata (mem_rdata)
   );

   `VGS_ASSERT_NEXT(a_busy_after_query, clock, reset, req_ch.valid && req_ch.ready && req_ch.command != vgs_pkg::CMD_WRITE, !req_ch.ready)
   `VGS_ASSERT_IMPLIES(a_write_to_store, clock, reset, req_ch.valid && req_ch.ready && req_ch.command == vgs_pkg::CMD_WRITE, mem_cmd.we && !mem_cmd.re)
   `VGS_ASSERT_IMPLIES(a_read_only_busy, clock, reset, mem_cmd.re, !req_ch.ready && !mem_cmd.we)
   `VGS_ASSERT_IMPLIES(a_border_zero, clock, reset, rsp_ch.valid && rsp_ch.border_flag, rsp_ch.result_x == '0 && rsp_ch.result_y == '0 && !rsp_ch.saturated)

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the vector grid sampler and stencil unit.
`timescale 1ns / 1ps

module tb_top;
   import vgs_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      cmd_type                      command;
      logic [COL_BITS-1:0]          col;
      logic [ROW_BITS-1:0]          row;
      logic signed [VALUE_BITS-1:0] vx;
      logic signed [VALUE_BITS-1:0] vy;
      logic signed [POS_BITS-1:0]   px;
      logic signed [POS_BITS-1:0]   py;
   } grid_request;

   typedef struct {
      logic signed [VALUE_BITS-1:0] rx;
      logic signed [VALUE_BITS-1:0] ry;
      logic                         border;
      logic                         sat;
   } grid_response;

   typedef struct {
      grid_request  rq;
      bit           typed;
      grid_response rsp;
   } stim_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   vgs_req_if req_ch();
   vgs_rsp_if rsp_ch();

   vector_grid_sample_and_stencil i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // shadow of the grid and of the registers
   logic signed [VALUE_BITS-1:0] grid_vx [DEPTH];
   logic signed [VALUE_BITS-1:0] grid_vy [DEPTH];
   bit                           cell_written [DEPTH];
   logic [SIZE_BITS-1:0]         cfg_width      = 7'd64;
   logic [SIZE_BITS-1:0]         cfg_height     = 7'd64;
   logic [RECIP_BITS-1:0]        cfg_inv_two_cw = 16'd128;
   logic [RECIP_BITS-1:0]        cfg_inv_cw_sq  = 16'd256;

   grid_response pending_responses [$];
   stim_row      directed_table [$];

   int          req_gap_pct    = 0;
   int          rsp_stall_pct  = 0;
   int          stall_left     = 0;
   int          mismatch_count = 0;
   int          requests_sent  = 0;
   int          results_seen   = 0;
   int          border_seen    = 0;
   int          saturated_seen = 0;
   int unsigned cycle_count    = 0;

   function automatic int eff_size(input logic [SIZE_BITS-1:0] v, input int max_v);
      if (v < 2) return 2;
      if (v > max_v) return max_v;
      return int'(v);
   endfunction

   function automatic longint clamp_pos(input longint p, input int size);
      longint lim;
      lim = longint'(size - 2) <<< FRAC_BITS;
      if (p < 0) return 0;
      if (p > lim) return lim;
      return p;
   endfunction

   function automatic longint round_shift(input longint v);
      return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic longint lerp(input longint a, input longint b, input longint t);
      return a + round_shift((b - a) * t);
   endfunction

   function automatic longint clip_value(input longint v, inout bit sat);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint cell_comp(input int col, input int row, input int comp);
      int addr;
      addr = row * MAX_COLS + col;
      return (comp == 0) ? longint'(grid_vx[addr]) : longint'(grid_vy[addr]);
   endfunction

   function automatic bit on_border(input int col, input int row, input int w, input int h);
      return col == 0 || col + 1 >= w || row == 0 || row + 1 >= h;
   endfunction

   // Apply one request to the shadow grid; return 1 when it yields a response.
   function automatic bit compute_grid_response(input grid_request rq,
                                                output grid_response rsp);
      int     w;
      int     h;
      int     col;
      int     row;
      int     x1;
      int     y1;
      int     addr;
      longint px;
      longint py;
      longint tx;
      longint ty;
      longint lo;
      longint hi;
      longint sum;
      longint v;
      bit     sat;
      w = eff_size(cfg_width, MAX_COLS);
      h = eff_size(cfg_height, MAX_ROWS);
      col = int'(rq.col);
      row = int'(rq.row);
      sat = 1'b0;
      rsp.rx = '0;
      rsp.ry = '0;
      rsp.border = 1'b0;
      rsp.sat = 1'b0;
      case (rq.command)
         CMD_WRITE: begin
            addr = row * MAX_COLS + col;
            grid_vx[addr] = rq.vx;
            grid_vy[addr] = rq.vy;
            cell_written[addr] = 1'b1;
            return 1'b0;
         end
         CMD_SAMPLE: begin
            px = clamp_pos(longint'(rq.px), w);
            py = clamp_pos(longint'(rq.py), h);
            x1 = int'(px >>> FRAC_BITS);
            y1 = int'(py >>> FRAC_BITS);
            tx = px & ((longint'(1) <<< FRAC_BITS) - 1);
            ty = py & ((longint'(1) <<< FRAC_BITS) - 1);
            for (int c = 0; c < 2; c++) begin
               lo = lerp(cell_comp(x1, y1, c), cell_comp(x1 + 1, y1, c), tx);
               hi = lerp(cell_comp(x1, y1 + 1, c), cell_comp(x1 + 1, y1 + 1, c), tx);
               v = clip_value(lerp(lo, hi, ty), sat);
               if (c == 0) rsp.rx = VALUE_BITS'(v);
               else rsp.ry = VALUE_BITS'(v);
            end
         end
         CMD_DIV, CMD_LAP: begin
            if (on_border(col, row, w, h)) begin
               rsp.border = 1'b1;
            end else if (rq.command == CMD_DIV) begin
               sum = cell_comp(col + 1, row, 0) - cell_comp(col - 1, row, 0)
                   + cell_comp(col, row + 1, 1) - cell_comp(col, row - 1, 1);
               v = clip_value(round_shift(sum * longint'(cfg_inv_two_cw)), sat);
               rsp.rx = VALUE_BITS'(v);
            end else begin
               for (int c = 0; c < 2; c++) begin
                  sum = cell_comp(col + 1, row, c) + cell_comp(col - 1, row, c)
                      + cell_comp(col, row + 1, c) + cell_comp(col, row - 1, c)
                      - 4 * cell_comp(col, row, c);
                  v = clip_value(round_shift(sum * longint'(cfg_inv_cw_sq)), sat);
                  if (c == 0) rsp.rx = VALUE_BITS'(v);
                  else rsp.ry = VALUE_BITS'(v);
               end
            end
         end
      endcase
      rsp.sat = sat;
      return 1'b1;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endfunction

   function automatic void table_write(input int col, input int row, input int vx,
                                       input int vy);
      stim_row r;
      r.rq.command = CMD_WRITE;
      r.rq.col = COL_BITS'(col);
      r.rq.row = ROW_BITS'(row);
      r.rq.vx = VALUE_BITS'(vx);
      r.rq.vy = VALUE_BITS'(vy);
      r.rq.px = '0;
      r.rq.py = '0;
      r.typed = 1'b0;
      r.rsp = '{'0, '0, 1'b0, 1'b0};
      directed_table.push_back(r);
   endfunction

   function automatic void table_query(input cmd_type cmd, input int col, input int row,
                                       input int px, input int py, input bit typed,
                                       input int rx, input int ry, input bit border,
                                       input bit sat);
      stim_row r;
      r.rq.command = cmd;
      r.rq.col = COL_BITS'(col);
      r.rq.row = ROW_BITS'(row);
      r.rq.vx = '0;
      r.rq.vy = '0;
      r.rq.px = POS_BITS'(px);
      r.rq.py = POS_BITS'(py);
      r.typed = typed;
      r.rsp = '{VALUE_BITS'(rx), VALUE_BITS'(ry), border, sat};
      directed_table.push_back(r);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return {1'b0, {(VALUE_BITS-1){1'b1}}};
      if (r == 1) return {1'b1, {(VALUE_BITS-1){1'b0}}};
      if (r < 5) return VALUE_BITS'(int'($urandom_range(0, 1023)) - 512);
      return VALUE_BITS'($urandom());
   endfunction

   function automatic logic signed [POS_BITS-1:0] pick_position(input int size);
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return POS_BITS'($urandom_range(0, (size - 1) << FRAC_BITS));
      if (r < 8) return POS_BITS'($urandom_range(0, size - 1) << FRAC_BITS);
      return POS_BITS'($urandom());
   endfunction

   function automatic int pick_coord(input int size, input int max_v);
      if ($urandom_range(0, 4) != 0) return $urandom_range(0, size - 1);
      return $urandom_range(0, max_v - 1);
   endfunction

   task automatic send_request(input grid_request rq, input bit typed,
                               input grid_response typed_rsp);
      grid_response rsp;
      @(negedge clock);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.command  = rq.command;
      req_ch.cell_col = rq.col;
      req_ch.cell_row = rq.row;
      req_ch.write_vx = rq.vx;
      req_ch.write_vy = rq.vy;
      req_ch.pos_x    = rq.px;
      req_ch.pos_y    = rq.py;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      if (compute_grid_response(rq, rsp)) pending_responses.push_back(typed ? typed_rsp : rsp);
   endtask

   // Write random vectors into every cell the request would read that holds none yet.
   task automatic fill_unwritten(input grid_request rq);
      int           addr_list [$];
      int           w;
      int           h;
      int           x1;
      int           y1;
      grid_request  wr;
      grid_response unused;
      w = eff_size(cfg_width, MAX_COLS);
      h = eff_size(cfg_height, MAX_ROWS);
      unused = '{'0, '0, 1'b0, 1'b0};
      if (rq.command == CMD_SAMPLE) begin
         x1 = int'(clamp_pos(longint'(rq.px), w) >>> FRAC_BITS);
         y1 = int'(clamp_pos(longint'(rq.py), h) >>> FRAC_BITS);
         addr_list = '{y1 * MAX_COLS + x1, y1 * MAX_COLS + x1 + 1,
                       (y1 + 1) * MAX_COLS + x1, (y1 + 1) * MAX_COLS + x1 + 1};
      end else if (!on_border(int'(rq.col), int'(rq.row), w, h)) begin
         x1 = int'(rq.col);
         y1 = int'(rq.row);
         addr_list = '{y1 * MAX_COLS + x1, y1 * MAX_COLS + x1 + 1, y1 * MAX_COLS + x1 - 1,
                       (y1 + 1) * MAX_COLS + x1, (y1 - 1) * MAX_COLS + x1};
      end
      foreach (addr_list[i]) begin
         if (!cell_written[addr_list[i]]) begin
            wr.command = CMD_WRITE;
            wr.col = COL_BITS'(addr_list[i] % MAX_COLS);
            wr.row = ROW_BITS'(addr_list[i] / MAX_COLS);
            wr.vx = pick_value();
            wr.vy = pick_value();
            wr.px = POS_BITS'($urandom());
            wr.py = POS_BITS'($urandom());
            send_request(wr, 1'b0, unused);
         end
      end
   endtask

   task automatic send_random_command();
      grid_request  rq;
      grid_response unused;
      int           r;
      int           w;
      int           h;
      w = eff_size(cfg_width, MAX_COLS);
      h = eff_size(cfg_height, MAX_ROWS);
      unused = '{'0, '0, 1'b0, 1'b0};
      r = $urandom_range(0, 99);
      rq.command = (r < 30) ? CMD_WRITE : (r < 55) ? CMD_SAMPLE : (r < 75) ? CMD_DIV : CMD_LAP;
      rq.col = COL_BITS'(pick_coord(w, MAX_COLS));
      rq.row = ROW_BITS'(pick_coord(h, MAX_ROWS));
      rq.vx = pick_value();
      rq.vy = pick_value();
      rq.px = pick_position(w);
      rq.py = pick_position(h);
      if (rq.command != CMD_WRITE) fill_unwritten(rq);
      send_request(rq, 1'b0, unused);
   endtask

   // count covers every request sent, fill writes included
   task automatic run_random(input int count, input int gap_pct, input int stall_pct);
      int stop_at;
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) send_random_command();
   endtask

   // Drop valid, let every pending response drain, then allow the block to go idle.
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_GRID_WIDTH:  cfg_width      = value[SIZE_BITS-1:0];
         REG_GRID_HEIGHT: cfg_height     = value[SIZE_BITS-1:0];
         REG_INV_TWO_CW:  cfg_inv_two_cw = value[RECIP_BITS-1:0];
         REG_INV_CW_SQ:   cfg_inv_cw_sq  = value[RECIP_BITS-1:0];
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_config(input int w, input int h, input int inv_two, input int inv_sq);
      csr_write(REG_GRID_WIDTH, CSR_DATA_BITS'(w));
      csr_write(REG_GRID_HEIGHT, CSR_DATA_BITS'(h));
      csr_write(REG_INV_TWO_CW, CSR_DATA_BITS'(inv_two));
      csr_write(REG_INV_CW_SQ, CSR_DATA_BITS'(inv_sq));
   endtask

   // response side: stall in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_ch.ready = 1'b0;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_responses
      grid_response want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.border_flag === 1'b1) border_seen++;
         if (rsp_ch.saturated === 1'b1) saturated_seen++;
         if (pending_responses.size() == 0) begin
            note_mismatch($sformatf("response %0d with none pending: x=%0d y=%0d",
                                    results_seen, rsp_ch.result_x, rsp_ch.result_y));
         end else begin
            want = pending_responses.pop_front();
            if (rsp_ch.result_x !== want.rx)
               note_mismatch($sformatf("response %0d result_x: expected %0d, got %0d",
                                       results_seen, want.rx, rsp_ch.result_x));
            if (rsp_ch.result_y !== want.ry)
               note_mismatch($sformatf("response %0d result_y: expected %0d, got %0d",
                                       results_seen, want.ry, rsp_ch.result_y));
            if (rsp_ch.border_flag !== want.border)
               note_mismatch($sformatf("response %0d border_flag: expected %0b, got %0b",
                                       results_seen, want.border, rsp_ch.border_flag));
            if (rsp_ch.saturated !== want.sat)
               note_mismatch($sformatf("response %0d saturated: expected %0b, got %0b",
                                       results_seen, want.sat, rsp_ch.saturated));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses pending",
                  cycle_count, pending_responses.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_WRITE;
      req_ch.cell_col = '0;
      req_ch.cell_row = '0;
      req_ch.write_vx = '0;
      req_ch.write_vy = '0;
      req_ch.pos_x    = '0;
      req_ch.pos_y    = '0;
      rsp_ch.ready    = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      foreach (cell_written[i]) cell_written[i] = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corner cells at the extremes; zero fraction returns the cell itself
      table_write(0, 0, 32767, -32768);
      table_write(1, 0, 32767, -32768);
      table_write(0, 1, 32767, -32768);
      table_write(1, 1, 32767, -32768);
      table_query(CMD_SAMPLE, 0, 0, 0, 0, 1'b1, 32767, -32768, 1'b0, 1'b0);
      table_query(CMD_SAMPLE, 0, 0, -16384, -16384, 1'b1, 32767, -32768, 1'b0, 1'b0);
      table_query(CMD_SAMPLE, 0, 0, 128, 255, 1'b0, 0, 0, 1'b0, 1'b0);
      // stencils on border cells
      table_query(CMD_DIV, 0, 5, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
      table_query(CMD_LAP, 63, 63, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
      table_query(CMD_LAP, 5, 0, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
      table_query(CMD_DIV, 62, 63, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
      // cross around (2,2): positive laplacian clips high
      table_write(1, 2, 32767, 32767);
      table_write(3, 2, 32767, 32767);
      table_write(2, 1, 32767, 32767);
      table_write(2, 3, 32767, 32767);
      table_write(2, 2, -32768, -32768);
      table_query(CMD_LAP, 2, 2, 0, 0, 1'b1, 32767, 32767, 1'b0, 1'b1);
      table_query(CMD_DIV, 2, 2, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
      // negative divergence clips low
      table_write(3, 2, -32768, -32768);
      table_write(2, 3, -32768, -32768);
      table_query(CMD_DIV, 2, 2, 0, 0, 1'b1, -32768, 0, 1'b0, 1'b1);
      // far corner: position beyond the grid clamps onto cell (62,62)
      table_write(62, 62, -1, 21845);
      table_write(63, 62, 1234, -4321);
      table_write(62, 63, -21846, 77);
      table_write(63, 63, 0, -1);
      table_query(CMD_SAMPLE, 0, 0, 16383, 16383, 1'b1, -1, 21845, 1'b0, 1'b0);

      req_gap_pct = 20;
      rsp_stall_pct = 20;
      foreach (directed_table[i])
         send_request(directed_table[i].rq, directed_table[i].typed, directed_table[i].rsp);

      settle();
      set_config(2, 2, 0, 65535);
      run_random(70, 20, 20);
      settle();
      set_config(64, 64, 65535, 0);
      run_random(70, 0, 25);
      settle();
      set_config(127, 1, $urandom_range(0, 65535), $urandom_range(0, 65535));
      run_random(70, 25, 0);
      settle();
      set_config(0, 100, $urandom_range(0, 1024), $urandom_range(0, 1024));
      run_random(70, 15, 15);
      settle();
      set_config($urandom_range(3, 12), $urandom_range(3, 12),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      run_random(80, 20, 30);
      settle();
      set_config(5, 64, 256, 128);
      run_random(70, 10, 10);
      // last stretch runs at full rate
      settle();
      set_config(64, 64, 128, 256);
      run_random(70, 0, 0);
      settle();

      $display("Sent %0d requests and checked %0d responses (%0d border, %0d clipped)",
               requests_sent, results_seen, border_seen, saturated_seen);
      $display("Grid sizes 2x2 to 64x64 and reciprocals 0 to 65535 covered, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
